>>> hw/rtl/lse_pkg.sv
// Package: types, opcodes and status codes for the LIFO stack engine.
package lse_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int OUT_W       = 7;

   localparam logic [2:0] OP_PUSH    = 3'd0;
   localparam logic [2:0] OP_POP     = 3'd1;
   localparam logic [2:0] OP_PEEK    = 3'd2;
   localparam logic [2:0] OP_SEARCH  = 3'd3;
   localparam logic [2:0] OP_REVERSE = 3'd4;
   localparam logic [2:0] OP_SORT    = 3'd5;
   localparam logic [2:0] OP_CLEAR   = 3'd6;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_MISS  = 2'd3;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value_out;
      logic [1:0]         status;
      logic [OUT_W-1:0]   position;
      logic [OUT_W-1:0]   depth_now;
   } rsp_type;

endpackage

>>> hw/rtl/lifo_stack_engine_top.sv
// Top level of the LIFO stack engine: sequencer around one stack RAM.
//
// Usage: drive req_data and pulse start while busy is low; that beat is taken.
// Each operation returns exactly one result beat on rsp_data, marked by
// rsp_valid for one cycle; the receiver cannot stall it.
// Push, clear and no-op answer in the cycle after start.
// Pop and peek issue one RAM read and answer from state S_RD.
// Search reads one entry per cycle from the top until a match or the bottom.
// Reverse swaps one pair at a time through states S_RV_A, S_RV_B and S_SO_W.
// Sort is an insertion sort (ascending, signed compare): each shift of an
// entry passes through states S_SO_R and S_SO_C.
// The single RAM read port paces all these operations.
// Reset (synchronous, active high) empties the stack; entries
// are not cleared since only slots below the fill count are ever read.
module lifo_stack_engine_top
   import lse_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;  // pop/peek data return
   localparam logic [3:0] S_SRCH  = 4'd2;
   localparam logic [3:0] S_RV_A  = 4'd3;  // lo data back, read hi issued
   localparam logic [3:0] S_RV_B  = 4'd4;  // hi data back, write lo
   localparam logic [3:0] S_SO_K  = 4'd6;  // key read issued
   localparam logic [3:0] S_SO_R  = 4'd7;  // entries[j-1] read issued
   localparam logic [3:0] S_SO_C  = 4'd8;  // compare / shift
   localparam logic [3:0] S_SO_W  = 4'd9;  // write key

   logic [3:0]        state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic [CNT_W-1:0]  i_ff, i_in;     // scan index / lo / sort i
   logic [CNT_W-1:0]  j_ff, j_in;     // hi / sort j
   logic [31:0]       key_ff, key_in;
   logic [31:0]       tmp_ff, tmp_in;
   logic [1:0]        rop_ff, rop_in; // 1 pop/peek pending, 2 reverse write to hi pending
   rsp_type           rsp_ff, rsp_in;
   logic              vld_ff, vld_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [31:0]       wr_data, rd_data;

   lse_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   function automatic rsp_type mk(logic [31:0] v, logic [1:0] s,
                                  logic [CNT_W-1:0] p, logic [CNT_W-1:0] d);
      rsp_type r;
      r.value_out = v;
      r.status    = s;
      r.position  = OUT_W'(p);
      r.depth_now = OUT_W'(d);
      return r;
   endfunction

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      key_in   = key_ff;
      tmp_in   = tmp_ff;
      rop_in   = rop_ff;
      rsp_in   = rsp_ff;
      vld_in   = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = '0;
      wr_data  = '0;
      rd_addr  = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               key_in = req_data.value_in;
               unique case (req_data.op)
                  OP_PUSH: begin
                     vld_in = 1'b1;
                     if (fill_ff >= CNT_W'(STACK_DEPTH)) begin
                        rsp_in = mk('0, ST_FULL, '0, fill_ff);
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = ADDR_W'(fill_ff);
                        wr_data = req_data.value_in;
                        fill_in = fill_ff + 1'b1;
                        rsp_in  = mk('0, ST_OK, '0, fill_ff + 1'b1);
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (fill_ff == '0) begin
                        vld_in = 1'b1;
                        rsp_in = mk('0, ST_EMPTY, '0, fill_ff);
                     end else begin
                        rd_addr  = ADDR_W'(fill_ff - 1'b1);
                        rop_in   = 2'd1;
                        if (req_data.op == OP_POP) fill_in = fill_ff - 1'b1;
                        state_in = S_RD;
                     end
                  end
                  OP_SEARCH: begin
                     if (fill_ff == '0) begin
                        vld_in = 1'b1;
                        rsp_in = mk('0, ST_MISS, '0, fill_ff);
                     end else begin
                        rd_addr  = ADDR_W'(fill_ff - 1'b1);
                        i_in     = fill_ff - 1'b1;
                        state_in = S_SRCH;
                     end
                  end
                  OP_REVERSE: begin
                     if (fill_ff < CNT_W'(2)) begin
                        vld_in = 1'b1;
                        rsp_in = mk('0, ST_OK, '0, fill_ff);
                     end else begin
                        i_in     = '0;
                        j_in     = fill_ff - 1'b1;
                        rd_addr  = '0;
                        state_in = S_RV_A;
                     end
                  end
                  OP_SORT: begin
                     if (fill_ff < CNT_W'(2)) begin
                        vld_in = 1'b1;
                        rsp_in = mk('0, ST_OK, '0, fill_ff);
                     end else begin
                        i_in     = CNT_W'(1);
                        rd_addr  = ADDR_W'(1);
                        state_in = S_SO_K;
                     end
                  end
                  OP_CLEAR: begin
                     vld_in  = 1'b1;
                     fill_in = '0;
                     rsp_in  = mk('0, ST_OK, '0, '0);
                  end
                  default: begin
                     vld_in = 1'b1;
                     rsp_in = mk('0, ST_OK, '0, fill_ff);
                  end
               endcase
            end
         end
         S_RD: begin
            vld_in   = 1'b1;
            rsp_in   = mk(rd_data, ST_OK, '0, fill_ff);
            rop_in   = '0;
            state_in = S_IDLE;
         end
         S_SRCH: begin
            // rd_data is entry i_ff
            if (rd_data == key_ff) begin
               vld_in   = 1'b1;
               rsp_in   = mk('0, ST_OK, fill_ff - i_ff, fill_ff);
               state_in = S_IDLE;
            end else if (i_ff == '0) begin
               vld_in   = 1'b1;
               rsp_in   = mk('0, ST_MISS, '0, fill_ff);
               state_in = S_IDLE;
            end else begin
               i_in     = i_ff - 1'b1;
               rd_addr  = ADDR_W'(i_ff - 1'b1);
            end
         end
         S_RV_A: begin
            tmp_in   = rd_data;  // entries[lo]
            rd_addr  = ADDR_W'(j_ff);
            state_in = S_RV_B;
         end
         S_RV_B: begin
            // two writes needed: write hi data to lo now, old lo to hi next
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(i_ff);
            wr_data = rd_data;
            key_in  = tmp_ff;
            state_in = S_SO_W;   // reuse write-key state with rop marking
            rop_in  = 2'd2;
         end
         S_SO_K: begin
            key_in   = rd_data;  // entries[i]
            j_in     = i_ff;
            rd_addr  = ADDR_W'(i_ff - 1'b1);
            state_in = S_SO_R;
         end
         S_SO_R: begin
            state_in = S_SO_C;
            tmp_in   = rd_data;
         end
         S_SO_C: begin
            // tmp_ff = entries[j-1]
            if ($signed(tmp_ff) > $signed(key_ff)) begin
               wr_en   = 1'b1;
               wr_addr = ADDR_W'(j_ff);
               wr_data = tmp_ff;
               j_in    = j_ff - 1'b1;
               if (j_ff == CNT_W'(1)) begin
                  state_in = S_SO_W;
               end else begin
                  rd_addr  = ADDR_W'(j_ff - CNT_W'(2));
                  state_in = S_SO_R;
               end
            end else begin
               state_in = S_SO_W;
            end
         end
         S_SO_W: begin
            wr_en   = 1'b1;
            wr_data = key_ff;
            if (rop_ff == 2'd2) begin
               // reverse: old lo goes to hi
               wr_addr = ADDR_W'(j_ff);
               rop_in  = '0;
               if (j_ff - i_ff <= CNT_W'(2)) begin
                  vld_in   = 1'b1;
                  rsp_in   = mk('0, ST_OK, '0, fill_ff);
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  j_in     = j_ff - 1'b1;
                  rd_addr  = ADDR_W'(i_ff + 1'b1);
                  state_in = S_RV_A;
               end
            end else begin
               wr_addr = ADDR_W'(j_ff);
               if (i_ff + 1'b1 >= fill_ff) begin
                  vld_in   = 1'b1;
                  rsp_in   = mk('0, ST_OK, '0, fill_ff);
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  rd_addr  = ADDR_W'(i_ff + 1'b1);
                  state_in = S_SO_K;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         vld_ff   <= 1'b0;
         rop_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         vld_ff   <= vld_in;
         rop_ff   <= rop_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      key_ff <= key_in;
      tmp_ff <= tmp_in;
      rsp_ff <= rsp_in;
   end
endmodule

>>> hw/rtl/lse_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
module lse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
